// ----- hw/rtl/c8ic_pkg.sv -----
// ----------------------------------------------------------------------------
// c8ic_pkg
// Shared types, codes and constants of the CHIP-8 instruction core.
// ----------------------------------------------------------------------------
package c8ic_pkg;

   localparam int MEM_BYTES       = 4096;
   localparam int ADDR_W          = 12;
   localparam int STACK_DEPTH_DEF = 16;
   localparam int SCREEN_WIDTH    = 64;
   localparam int SCREEN_HEIGHT   = 32;
   localparam int ROW_W           = 5;
   localparam int PC_W            = 13;
   localparam int SP_W            = 5;
   localparam int CNT_W           = 4;
   localparam int NUM_REGS        = 16;

   localparam logic [PC_W-1:0] PC_RESET = 13'h200;

   localparam logic [1:0] MODE_LOAD = 2'd0;
   localparam logic [1:0] MODE_EXEC = 2'd1;
   localparam logic [1:0] MODE_TICK = 2'd2;
   localparam logic [1:0] MODE_ROW  = 2'd3;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_WAIT_KEY   = 2'd1;
   localparam logic [1:0] ST_STACK_HALT = 2'd2;
   localparam logic [1:0] ST_PC_HALT    = 2'd3;

   localparam logic [7:0] OPC_CLS       = 8'hE0;
   localparam logic [7:0] OPC_RET       = 8'hEE;
   localparam logic [7:0] OPC_SKP       = 8'h9E;
   localparam logic [7:0] OPC_SKNP      = 8'hA1;
   localparam logic [7:0] OPC_GET_DT    = 8'h07;
   localparam logic [7:0] OPC_WAIT_KEY  = 8'h0A;
   localparam logic [7:0] OPC_SET_DT    = 8'h15;
   localparam logic [7:0] OPC_SET_ST    = 8'h18;
   localparam logic [7:0] OPC_ADD_I     = 8'h1E;
   localparam logic [7:0] OPC_FONT      = 8'h29;
   localparam logic [7:0] OPC_BCD       = 8'h33;
   localparam logic [7:0] OPC_STORE     = 8'h55;
   localparam logic [7:0] OPC_FILL      = 8'h65;

   typedef struct packed {
      logic [1:0]        mode;
      logic [ADDR_W-1:0] address;
      logic [7:0]        load_byte;
      logic [15:0]       key_mask;
      logic [7:0]        random_byte;
   } req_type;

   typedef struct packed {
      logic [PC_W-1:0]         program_counter;
      logic [15:0]             fetched_opcode;
      logic [1:0]              status;
      logic                    draw_flag;
      logic                    sound_active;
      logic [SCREEN_WIDTH-1:0] display_row;
   } rsp_type;

   typedef enum logic [4:0] {
      CMD_NONE, CMD_START, CMD_LOAD, CMD_TICK, CMD_ROW_RD, CMD_ROW_CAP,
      CMD_PC_HALT, CMD_FETCH0, CMD_FETCH1, CMD_FETCH2, CMD_RDX, CMD_RDY,
      CMD_RDW, CMD_EXEC, CMD_DRAW_RD, CMD_DRAW_WR, CMD_BCD, CMD_STORE_RD,
      CMD_STORE_WR, CMD_FILL_RD, CMD_FILL_WR, CMD_WRF, CMD_WRX, CMD_RESP
   } cmd_type;

   typedef enum logic [2:0] {
      CL_SIMPLE, CL_DRAW, CL_BCD, CL_STORE, CL_FILL
   } class_type;

   typedef struct packed {
      logic [1:0] mode;
      logic       halted;
      logic       pc_oob;
      class_type  op_class;
      logic       draw_empty;
      logic       cnt_last;
      logic       rsp_busy;
   } dp_status_type;

endpackage

// ----- hw/rtl/chip8_instruction_core_unit.sv -----
// One transfer at a time: the next is taken once the result register has
// been loaded.
// Reset: control, registers, stack and timers clear, PC to 0x200; register
// file and framebuffer read as zero via valid bits; main memory not cleared.
// ----------------------------------------------------------------------------
// chip8_instruction_core_unit
// CHIP-8 interpreter core: sequencer plus datapath.
// ----------------------------------------------------------------------------
module chip8_instruction_core_unit #(
   parameter int STACK_DEPTH = c8ic_pkg::STACK_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  c8ic_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output c8ic_pkg::rsp_type rsp_data
);
   import c8ic_pkg::*;

   cmd_type       cmd;
   dp_status_type dp_status;

   c8ic_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .dp_status(dp_status), .cmd(cmd)
   );

   c8ic_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req_data(req_data),
      .dp_status(dp_status), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

endmodule

// ----- hw/rtl/c8ic_ram.sv -----
// ----------------------------------------------------------------------------
// c8ic_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module c8ic_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hw/rtl/c8ic_ctrl.sv -----
// ----------------------------------------------------------------------------
// c8ic_ctrl
// Sequencer: steps load, tick and row transfers, and walks an execute through
// fetch, operand read, execute and the multi-step sprite, BCD, store and fill loops.
// ----------------------------------------------------------------------------
module c8ic_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  c8ic_pkg::dp_status_type dp_status,
   output c8ic_pkg::cmd_type      cmd
);
   import c8ic_pkg::*;

   typedef enum logic [20:0] {
      S_IDLE     = 21'h000001,
      S_DISPATCH = 21'h000002,
      S_FETCH0   = 21'h000004,
      S_FETCH1   = 21'h000008,
      S_FETCH2   = 21'h000010,
      S_RDX      = 21'h000020,
      S_RDY      = 21'h000040,
      S_RDW      = 21'h000080,
      S_EXEC     = 21'h000100,
      S_DRAW_RD  = 21'h000200,
      S_DRAW_WR  = 21'h000400,
      S_BCD      = 21'h000800,
      S_STORE_RD = 21'h001000,
      S_STORE_WR = 21'h002000,
      S_FILL_RD  = 21'h004000,
      S_FILL_WR  = 21'h008000,
      S_WRF      = 21'h010000,
      S_WRX      = 21'h020000,
      S_ROW_RD   = 21'h040000,
      S_ROW_CAP  = 21'h080000,
      S_DONE     = 21'h100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd      = CMD_START;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (dp_status.mode)
               MODE_LOAD: begin
                  cmd      = CMD_LOAD;
                  state_in = S_DONE;
               end
               MODE_TICK: begin
                  cmd      = CMD_TICK;
                  state_in = S_DONE;
               end
               MODE_ROW: begin
                  state_in = S_ROW_RD;
               end
               MODE_EXEC: begin
                  if (dp_status.halted) begin
                     state_in = S_DONE;
                  end else if (dp_status.pc_oob) begin
                     cmd      = CMD_PC_HALT;
                     state_in = S_DONE;
                  end else begin
                     state_in = S_FETCH0;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_ROW_RD: begin
            cmd      = CMD_ROW_RD;
            state_in = S_ROW_CAP;
         end
         S_ROW_CAP: begin
            cmd      = CMD_ROW_CAP;
            state_in = S_DONE;
         end
         S_FETCH0: begin
            cmd      = CMD_FETCH0;
            state_in = S_FETCH1;
         end
         S_FETCH1: begin
            cmd      = CMD_FETCH1;
            state_in = S_FETCH2;
         end
         S_FETCH2: begin
            cmd      = CMD_FETCH2;
            state_in = S_RDX;
         end
         S_RDX: begin
            cmd      = CMD_RDX;
            state_in = S_RDY;
         end
         S_RDY: begin
            cmd      = CMD_RDY;
            state_in = S_RDW;
         end
         S_RDW: begin
            cmd      = CMD_RDW;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd = CMD_EXEC;
            case (dp_status.op_class)
               CL_DRAW:  state_in = dp_status.draw_empty ? S_WRF : S_DRAW_RD;
               CL_BCD:   state_in = S_BCD;
               CL_STORE: state_in = S_STORE_RD;
               CL_FILL:  state_in = S_FILL_RD;
               default:  state_in = S_WRF;
            endcase
         end
         S_DRAW_RD: begin
            cmd      = CMD_DRAW_RD;
            state_in = S_DRAW_WR;
         end
         S_DRAW_WR: begin
            cmd      = CMD_DRAW_WR;
            state_in = dp_status.cnt_last ? S_WRF : S_DRAW_RD;
         end
         S_BCD: begin
            cmd      = CMD_BCD;
            state_in = dp_status.cnt_last ? S_DONE : S_BCD;
         end
         S_STORE_RD: begin
            cmd      = CMD_STORE_RD;
            state_in = S_STORE_WR;
         end
         S_STORE_WR: begin
            cmd      = CMD_STORE_WR;
            state_in = dp_status.cnt_last ? S_DONE : S_STORE_RD;
         end
         S_FILL_RD: begin
            cmd      = CMD_FILL_RD;
            state_in = S_FILL_WR;
         end
         S_FILL_WR: begin
            cmd      = CMD_FILL_WR;
            state_in = dp_status.cnt_last ? S_DONE : S_FILL_RD;
         end
         S_WRF: begin
            cmd      = CMD_WRF;
            state_in = S_WRX;
         end
         S_WRX: begin
            cmd      = CMD_WRX;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!dp_status.rsp_busy) begin
               cmd      = CMD_RESP;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

// ----- hw/rtl/c8ic_dp.sv -----
// ----------------------------------------------------------------------------
// c8ic_dp
// Datapath: machine registers, memory, register file, framebuffer, return
// stack and the result register, stepped by the sequencer's commands.
// ----------------------------------------------------------------------------
module c8ic_dp #(
   parameter int STACK_DEPTH = c8ic_pkg::STACK_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  c8ic_pkg::cmd_type       cmd,
   input  c8ic_pkg::req_type       req_data,
   output c8ic_pkg::dp_status_type dp_status,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output c8ic_pkg::rsp_type       rsp_data
);
   import c8ic_pkg::*;

   localparam int SI_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   req_type                 req_ff, req_in;
   logic [PC_W-1:0]         pc_ff, pc_in, here_ff, here_in;
   logic [ADDR_W-1:0]       i_ff, i_in;
   logic [SP_W-1:0]         sp_ff, sp_in;
   logic [7:0]              dt_ff, dt_in, st_ff, st_in;
   logic                    halted_ff, halted_in;
   logic [1:0]              reason_ff, reason_in;
   logic [15:0]             op_ff, op_in;
   logic [7:0]              vx_ff, vx_in, vy_ff, vy_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    flag_ff, flag_in;
   logic [7:0]              res_ff, res_in;
   logic                    wrf_ff, wrf_in, wrx_ff, wrx_in;
   logic                    drew_ff, drew_in;
   logic [1:0]              status_ff, status_in;
   logic [SCREEN_WIDTH-1:0] row_ff, row_in;
   logic [PC_W-1:0]         stack_ff [STACK_DEPTH];
   logic [NUM_REGS-1:0]     vvalid_ff, vvalid_in;
   logic [SCREEN_HEIGHT-1:0] fbvalid_ff, fbvalid_in;
   logic                    vrvalid_ff, fbrvalid_ff;
   rsp_type                 rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
   logic [7:0]              mem_wdata, mem_rdata;
   logic                    v_we;
   logic [CNT_W-1:0]        v_waddr, v_raddr;
   logic [7:0]              v_wdata, v_rdata_raw, vdata;
   logic                    fb_we;
   logic [ROW_W-1:0]        fb_waddr, fb_raddr;
   logic [SCREEN_WIDTH-1:0] fb_wdata, fb_rdata_raw, fbrow;

   logic [3:0]              nib, xi, yi, nn;
   logic [7:0]              kk;
   logic [ADDR_W-1:0]       nnn, i_cnt;
   logic [PC_W-1:0]         pc_plus2;
   logic [ROW_W-1:0]        py;
   logic [SCREEN_WIDTH-1:0] sprite_base, pat;
   logic [6:0]              rot_left;
   logic [3:0]              key_num;
   logic                    key_any, key_down;
   logic [1:0]              hund;
   logic [7:0]              rem;
   logic [14:0]             tens_prod;
   logic [3:0]              tens, ones;
   logic [7:0]              digit;
   logic [CNT_W-1:0]        limit;
   logic [8:0]              sum9;
   logic [SP_W-1:0]         sp_dec;
   logic                    stack_push;
   class_type               op_class;

   c8ic_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_main_mem (
      .clock(clock), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
      .raddr(mem_raddr), .rdata(mem_rdata)
   );

   c8ic_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_vreg (
      .clock(clock), .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
      .raddr(v_raddr), .rdata(v_rdata_raw)
   );

   c8ic_ram #(.WIDTH(SCREEN_WIDTH), .DEPTH(SCREEN_HEIGHT)) u_fb (
      .clock(clock), .we(fb_we), .waddr(fb_waddr), .wdata(fb_wdata),
      .raddr(fb_raddr), .rdata(fb_rdata_raw)
   );

   assign nib      = op_ff[15:12];
   assign xi       = op_ff[11:8];
   assign yi       = op_ff[7:4];
   assign nn       = op_ff[3:0];
   assign kk       = op_ff[7:0];
   assign nnn      = op_ff[11:0];
   assign pc_plus2 = pc_ff + PC_W'(2);
   assign i_cnt    = i_ff + ADDR_W'(cnt_ff);
   assign py       = vy_ff[ROW_W-1:0] + ROW_W'(cnt_ff);
   assign vdata    = vrvalid_ff ? v_rdata_raw : 8'd0;
   assign fbrow    = fbrvalid_ff ? fb_rdata_raw : '0;
   assign sp_dec   = (sp_ff != '0) ? sp_ff - SP_W'(1) : '0;
   assign sum9     = {1'b0, vx_ff} + {1'b0, vy_ff};

   // sprite byte rotated to column vx, wrapping at the right edge
   assign sprite_base = {mem_rdata, {(SCREEN_WIDTH-8){1'b0}}};
   assign rot_left    = 7'd64 - {1'b0, vx_ff[5:0]};
   assign pat         = (sprite_base >> vx_ff[5:0]) | (sprite_base << rot_left);

   always_comb begin
      key_num = '0;
      for (int k = 0; k < 16; k++) begin
         if (req_ff.key_mask[k]) begin
            key_num = 4'(k);
         end
      end
   end
   assign key_any  = |req_ff.key_mask;
   assign key_down = (vx_ff[7:4] == 4'd0) && req_ff.key_mask[vx_ff[3:0]];

   // BCD digits, reciprocal multiply for the tens
   assign hund      = (vx_ff >= 8'd200) ? 2'd2 : ((vx_ff >= 8'd100) ? 2'd1 : 2'd0);
   assign rem       = vx_ff - 8'({hund, 2'b00} * 7'd25);
   assign tens_prod = {8'd0, rem[6:0]} * 15'd205;
   assign tens      = tens_prod[14:11];
   assign ones      = 4'(rem - {tens, 3'b000} - {3'b000, tens, 1'b0});
   always_comb begin
      case (cnt_ff)
         4'd0:    digit = {6'd0, hund};
         4'd1:    digit = {4'd0, tens};
         default: digit = {4'd0, ones};
      endcase
   end

   always_comb begin
      op_class = CL_SIMPLE;
      if (nib == 4'hD) begin
         op_class = CL_DRAW;
      end else if (nib == 4'hF && kk == OPC_BCD) begin
         op_class = CL_BCD;
      end else if (nib == 4'hF && kk == OPC_STORE) begin
         op_class = CL_STORE;
      end else if (nib == 4'hF && kk == OPC_FILL) begin
         op_class = CL_FILL;
      end
   end

   always_comb begin
      case (op_class)
         CL_DRAW:           limit = nn - 4'd1;
         CL_BCD:            limit = 4'd2;
         CL_STORE, CL_FILL: limit = xi;
         default:           limit = '0;
      endcase
   end

   assign stack_push = (cmd == CMD_EXEC) && (nib == 4'h2) &&
                       (sp_ff < SP_W'(STACK_DEPTH));

   always_comb begin
      req_in       = req_ff;
      pc_in        = pc_ff;
      here_in      = here_ff;
      i_in         = i_ff;
      sp_in        = sp_ff;
      dt_in        = dt_ff;
      st_in        = st_ff;
      halted_in    = halted_ff;
      reason_in    = reason_ff;
      op_in        = op_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      cnt_in       = cnt_ff;
      flag_in      = flag_ff;
      res_in       = res_ff;
      wrf_in       = wrf_ff;
      wrx_in       = wrx_ff;
      drew_in      = drew_ff;
      status_in    = status_ff;
      row_in       = row_ff;
      vvalid_in    = vvalid_ff;
      fbvalid_in   = fbvalid_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      mem_we       = 1'b0;
      mem_waddr    = i_cnt;
      mem_wdata    = vdata;
      mem_raddr    = i_cnt;
      v_we         = 1'b0;
      v_waddr      = cnt_ff;
      v_wdata      = mem_rdata;
      v_raddr      = cnt_ff;
      fb_we        = 1'b0;
      fb_waddr     = py;
      fb_wdata     = fbrow ^ pat;
      fb_raddr     = py;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (cmd)
         CMD_START: begin
            req_in    = req_data;
            op_in     = '0;
            drew_in   = 1'b0;
            status_in = ST_OK;
            row_in    = '0;
         end
         CMD_LOAD: begin
            mem_we    = 1'b1;
            mem_waddr = req_ff.address;
            mem_wdata = req_ff.load_byte;
         end
         CMD_TICK: begin
            if (dt_ff != 8'd0) dt_in = dt_ff - 8'd1;
            if (st_ff != 8'd0) st_in = st_ff - 8'd1;
         end
         CMD_ROW_RD: begin
            fb_raddr = req_ff.address[ROW_W-1:0];
         end
         CMD_ROW_CAP: begin
            row_in = (req_ff.address < ADDR_W'(SCREEN_HEIGHT)) ? fbrow : '0;
         end
         CMD_PC_HALT: begin
            halted_in = 1'b1;
            reason_in = ST_PC_HALT;
         end
         CMD_FETCH0: begin
            here_in   = pc_ff;
            mem_raddr = pc_ff[ADDR_W-1:0];
         end
         CMD_FETCH1: begin
            mem_raddr   = pc_ff[ADDR_W-1:0] + ADDR_W'(1);
            op_in[15:8] = mem_rdata;
         end
         CMD_FETCH2: begin
            op_in[7:0] = mem_rdata;
            pc_in      = pc_plus2;
         end
         CMD_RDX: begin
            v_raddr = xi;
         end
         CMD_RDY: begin
            v_raddr = (nib == 4'hB) ? 4'd0 : yi;
            vx_in   = vdata;
         end
         CMD_RDW: begin
            vy_in = vdata;
         end
         CMD_EXEC: begin
            cnt_in  = '0;
            flag_in = 1'b0;
            wrf_in  = 1'b0;
            wrx_in  = 1'b0;
            case (nib)
               4'h0: begin
                  if (kk == OPC_CLS) begin
                     fbvalid_in = '0;
                     drew_in    = 1'b1;
                  end else if (kk == OPC_RET) begin
                     sp_in = sp_dec;
                     pc_in = stack_ff[sp_dec[SI_W-1:0]];
                  end
               end
               4'h1: pc_in = {1'b0, nnn};
               4'h2: begin
                  if (sp_ff >= SP_W'(STACK_DEPTH)) begin
                     pc_in     = here_ff;
                     halted_in = 1'b1;
                     reason_in = ST_STACK_HALT;
                  end else begin
                     sp_in = sp_ff + SP_W'(1);
                     pc_in = {1'b0, nnn};
                  end
               end
               4'h3: if (vx_ff == kk) pc_in = pc_plus2;
               4'h4: if (vx_ff != kk) pc_in = pc_plus2;
               4'h5: if (vx_ff == vy_ff) pc_in = pc_plus2;
               4'h6: begin
                  res_in = kk;
                  wrx_in = 1'b1;
               end
               4'h7: begin
                  res_in = vx_ff + kk;
                  wrx_in = 1'b1;
               end
               4'h8: begin
                  case (nn)
                     4'h0: begin res_in = vy_ff;         wrx_in = 1'b1; end
                     4'h1: begin res_in = vx_ff | vy_ff; wrx_in = 1'b1; end
                     4'h2: begin res_in = vx_ff & vy_ff; wrx_in = 1'b1; end
                     4'h3: begin res_in = vx_ff ^ vy_ff; wrx_in = 1'b1; end
                     4'h4: begin
                        res_in  = sum9[7:0];
                        flag_in = sum9[8];
                        wrf_in  = 1'b1;
                        wrx_in  = 1'b1;
                     end
                     4'h5: begin
                        res_in  = vx_ff - vy_ff;
                        flag_in = vx_ff > vy_ff;
                        wrf_in  = 1'b1;
                        wrx_in  = 1'b1;
                     end
                     4'h6: begin
                        res_in  = {1'b0, vx_ff[7:1]};
                        flag_in = vx_ff[0];
                        wrf_in  = 1'b1;
                        wrx_in  = 1'b1;
                     end
                     4'h7: begin
                        res_in  = vy_ff - vx_ff;
                        flag_in = vy_ff > vx_ff;
                        wrf_in  = 1'b1;
                        wrx_in  = 1'b1;
                     end
                     4'hE: begin
                        res_in  = {vx_ff[6:0], 1'b0};
                        flag_in = vx_ff[7];
                        wrf_in  = 1'b1;
                        wrx_in  = 1'b1;
                     end
                     default: ;
                  endcase
               end
               4'h9: if (vx_ff != vy_ff) pc_in = pc_plus2;
               4'hA: i_in = nnn;
               4'hB: pc_in = {1'b0, nnn} + {5'd0, vy_ff};
               4'hC: begin
                  res_in = req_ff.random_byte & kk;
                  wrx_in = 1'b1;
               end
               4'hD: begin
                  drew_in = 1'b1;
                  wrf_in  = 1'b1;
               end
               4'hE: begin
                  if ((kk == OPC_SKP && key_down) || (kk == OPC_SKNP && !key_down)) begin
                     pc_in = pc_plus2;
                  end
               end
               default: begin
                  case (kk)
                     OPC_GET_DT: begin
                        res_in = dt_ff;
                        wrx_in = 1'b1;
                     end
                     OPC_WAIT_KEY: begin
                        if (key_any) begin
                           res_in = {4'd0, key_num};
                           wrx_in = 1'b1;
                        end else begin
                           pc_in     = here_ff;
                           status_in = ST_WAIT_KEY;
                        end
                     end
                     OPC_SET_DT: dt_in = vx_ff;
                     OPC_SET_ST: st_in = vx_ff;
                     OPC_ADD_I:  i_in = i_ff + {4'd0, vx_ff};
                     OPC_FONT:   i_in = ({4'd0, vx_ff} << 2) + {4'd0, vx_ff};
                     default: ;
                  endcase
               end
            endcase
         end
         CMD_DRAW_RD: begin
            mem_raddr = i_cnt;
            fb_raddr  = py;
         end
         CMD_DRAW_WR: begin
            if ((fbrow & pat) != '0) flag_in = 1'b1;
            fb_we          = 1'b1;
            fbvalid_in[py] = 1'b1;
            cnt_in         = cnt_ff + CNT_W'(1);
         end
         CMD_BCD: begin
            mem_we    = 1'b1;
            mem_wdata = digit;
            cnt_in    = cnt_ff + CNT_W'(1);
         end
         CMD_STORE_RD: begin
            v_raddr = cnt_ff;
         end
         CMD_STORE_WR: begin
            mem_we = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
         end
         CMD_FILL_RD: begin
            mem_raddr = i_cnt;
         end
         CMD_FILL_WR: begin
            v_we              = 1'b1;
            vvalid_in[cnt_ff] = 1'b1;
            cnt_in            = cnt_ff + CNT_W'(1);
         end
         CMD_WRF: begin
            if (wrf_ff) begin
               v_we          = 1'b1;
               v_waddr       = 4'hF;
               v_wdata       = {7'd0, flag_ff};
               vvalid_in[15] = 1'b1;
            end
         end
         CMD_WRX: begin
            if (wrx_ff) begin
               v_we          = 1'b1;
               v_waddr       = xi;
               v_wdata       = res_ff;
               vvalid_in[xi] = 1'b1;
            end
         end
         CMD_RESP: begin
            rsp_in.program_counter = pc_ff;
            rsp_in.fetched_opcode  = op_ff;
            rsp_in.status          = halted_ff ? reason_ff : status_ff;
            rsp_in.draw_flag       = drew_ff;
            rsp_in.sound_active    = st_ff != 8'd0;
            rsp_in.display_row     = row_ff;
            rsp_valid_in           = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_RESET;
         i_ff         <= '0;
         sp_ff        <= '0;
         dt_ff        <= '0;
         st_ff        <= '0;
         halted_ff    <= 1'b0;
         reason_ff    <= ST_OK;
         vvalid_ff    <= '0;
         fbvalid_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int s = 0; s < STACK_DEPTH; s++) begin
            stack_ff[s] <= '0;
         end
      end else begin
         pc_ff        <= pc_in;
         i_ff         <= i_in;
         sp_ff        <= sp_in;
         dt_ff        <= dt_in;
         st_ff        <= st_in;
         halted_ff    <= halted_in;
         reason_ff    <= reason_in;
         vvalid_ff    <= vvalid_in;
         fbvalid_ff   <= fbvalid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (stack_push) begin
            stack_ff[sp_ff[SI_W-1:0]] <= pc_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      here_ff     <= here_in;
      op_ff       <= op_in;
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      cnt_ff      <= cnt_in;
      flag_ff     <= flag_in;
      res_ff      <= res_in;
      wrf_ff      <= wrf_in;
      wrx_ff      <= wrx_in;
      drew_ff     <= drew_in;
      status_ff   <= status_in;
      row_ff      <= row_in;
      rsp_ff      <= rsp_in;
      vrvalid_ff  <= vvalid_ff[v_raddr];
      fbrvalid_ff <= fbvalid_ff[fb_raddr];
   end

   assign dp_status.mode       = req_ff.mode;
   assign dp_status.halted     = halted_ff;
   assign dp_status.pc_oob     = pc_ff[PC_W-1];
   assign dp_status.op_class   = op_class;
   assign dp_status.draw_empty = (nn == 4'd0);
   assign dp_status.cnt_last   = (cnt_ff == limit);
   assign dp_status.rsp_busy   = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hw/rtl/c8ic_checker.sv -----
// ----------------------------------------------------------------------------
// c8ic_checker
// Port-level checks of the CHIP-8 core, bound to the top level.
// ----------------------------------------------------------------------------
module c8ic_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input c8ic_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input c8ic_pkg::rsp_type rsp_data
);
   import c8ic_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed before transfer");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_wait_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_WAIT_KEY |->
         rsp_data.fetched_opcode[15:12] == 4'hF &&
         rsp_data.fetched_opcode[7:0] == OPC_WAIT_KEY && !rsp_data.draw_flag)
      else $error("wait status without key wait opcode");

   a_row_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fetched_opcode != 16'd0 |-> rsp_data.display_row == '0)
      else $error("row data on an execute result");

endmodule

bind chip8_instruction_core_unit c8ic_checker u_c8ic_checker (.*);
